/* hw/rtl/epa_pkg.sv */
// Package for the encoder period averager.
// Types, action codes and constants shared by controller, datapath and top level.
package epa_pkg;

    localparam int unsigned DataW    = 32;
    localparam int unsigned CountW   = $clog2(DataW);
    localparam logic [15:0] TimeoutReset = 16'd500;
    localparam logic [31:0] OverflowStep = 32'h0001_0000;
    localparam logic [15:0] MsSaturate   = 16'hFFFF;

    typedef enum logic [1:0] {
        ACT_EVENT = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic do_event;   // apply timer event
        logic do_tick;    // age ms counter
        logic do_read;    // timeout check, latch divider operands
        logic div_step;   // one quotient bit
        logic div_done;   // store quotient as held period
        logic out_load;   // load output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_needed; // read finds pulses after timeout check
        logic div_last;   // final quotient bit this cycle
    } status_t;

endpackage

/* hw/rtl/epa_ctrl.sv */
// Controller state machine for the encoder period averager.
// Depends on epa_pkg; drives cmd_t into epa_datapath and owns the output valid.
module epa_ctrl
    import epa_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [1:0]    in_action,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  status_t       status,
    output cmd_t          cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   slot_free;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_action == ACT_READ)
                begin
                    state_next = status.div_needed ? ST_DIVIDE : ST_DONE;
                end
            end
            ST_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.do_event = accept && (in_action == ACT_EVENT);
                cmd.do_tick  = accept && (in_action == ACT_TICK);
                cmd.do_read  = accept && (in_action == ACT_READ);
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cmd.div_done = status.div_last;
            end
            ST_DONE:
            begin
                cmd.out_load = slot_free;
            end
            default: cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* hw/rtl/epa_datapath.sv */
// Datapath for the encoder period averager: measurement state, timeout
// register, radix-2 restoring divider and output register. Depends on epa_pkg.
module epa_datapath
    import epa_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cmd_t          cmd,
    output status_t       status,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata,
    input  logic          overflow_flag,
    input  logic          capture_flag,
    input  logic [15:0]   capture_value,
    input  logic          direction,
    output logic [31:0]   period_ticks,
    output logic          running_flag
);

    logic [15:0] timeout_ms_reg;
    logic        running_reg, running_next;
    logic        last_dir_reg, last_dir_next;
    logic [31:0] ext_reg, ext_next;
    logic [31:0] sum_reg, sum_next;
    logic [31:0] pulse_reg, pulse_next;
    logic [31:0] held_reg, held_next;
    logic [15:0] ms_reg, ms_next;
    logic [CountW-1:0] cnt_reg, cnt_next;

    // divider operands, no reset
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [31:0] out_period_reg;
    logic        out_run_reg;

    logic        stop_now;
    logic        dir_change;
    logic        run1;
    logic [31:0] sum1, pulse1, ext1;
    logic [32:0] rem_sh, rem_sub;

    assign stop_now = running_reg && (ms_reg > timeout_ms_reg);

    assign status.div_needed = !stop_now && (pulse_reg != 32'd0);
    assign status.div_last   = (cnt_reg == CountW'(DataW - 1));

    assign dir_change = (last_dir_reg != direction);
    assign run1       = dir_change ? 1'b0 : running_reg;
    assign sum1       = dir_change ? 32'd0 : sum_reg;
    assign pulse1     = dir_change ? 32'd0 : pulse_reg;
    assign ext1       = overflow_flag ? (ext_reg + OverflowStep) : ext_reg;

    assign rem_sh  = {rem_reg, quo_reg[31]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        running_next  = running_reg;
        last_dir_next = last_dir_reg;
        ext_next      = ext_reg;
        sum_next      = sum_reg;
        pulse_next    = pulse_reg;
        held_next     = held_reg;
        ms_next       = ms_reg;
        cnt_next      = cnt_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        dvs_next      = dvs_reg;

        if (cmd.do_event)
        begin
            last_dir_next = direction;
            running_next  = run1;
            sum_next      = sum1;
            pulse_next    = pulse1;
            ext_next      = ext1;
            if (dir_change)
            begin
                held_next = 32'd0;
            end
            if (capture_flag)
            begin
                if (run1)
                begin
                    sum_next   = sum1 + ext1 + {16'd0, capture_value};
                    pulse_next = pulse1 + 32'd1;
                end
                else
                begin
                    running_next = 1'b1;
                    sum_next     = 32'd0;
                    pulse_next   = 32'd0;
                end
                ms_next  = 16'd0;
                ext_next = 32'd0;
            end
        end

        if (cmd.do_tick && ms_reg != MsSaturate)
        begin
            ms_next = ms_reg + 16'd1;
        end

        if (cmd.do_read)
        begin
            if (stop_now)
            begin
                running_next = 1'b0;
                held_next    = 32'd0;
            end
            // stop or division both leave sum and count cleared
            if (stop_now || pulse_reg != 32'd0)
            begin
                sum_next   = 32'd0;
                pulse_next = 32'd0;
            end
            quo_next = sum_reg;
            dvs_next = pulse_reg;
            rem_next = 32'd0;
            cnt_next = '0;
        end

        if (cmd.div_step)
        begin
            cnt_next = cnt_reg + CountW'(1);
            if (!rem_sub[32])
            begin
                rem_next = rem_sub[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
        end

        if (cmd.div_done)
        begin
            held_next = quo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ms_reg <= TimeoutReset;
            running_reg    <= 1'b0;
            last_dir_reg   <= 1'b0;
            ext_reg        <= 32'd0;
            sum_reg        <= 32'd0;
            pulse_reg      <= 32'd0;
            held_reg       <= 32'd0;
            ms_reg         <= 16'd0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_ms_reg <= cfg_wdata;
            end
            running_reg  <= running_next;
            last_dir_reg <= last_dir_next;
            ext_reg      <= ext_next;
            sum_reg      <= sum_next;
            pulse_reg    <= pulse_next;
            held_reg     <= held_next;
            ms_reg       <= ms_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        if (cmd.out_load)
        begin
            out_period_reg <= held_reg;
            out_run_reg    <= running_reg;
        end
    end

    assign period_ticks = out_period_reg;
    assign running_flag = out_run_reg;

endmodule

/* hw/rtl/encoder_period_averager.sv */
// Top level of the encoder period averager: controller plus datapath.
// Depends on epa_pkg, epa_ctrl and epa_datapath.
//
// Usage
//   Input channel (in_valid/in_ready) carries one request per item:
//   action selects timer event, millisecond tick or period read; the
//   event fields (overflow_flag, capture_flag, capture_value, direction)
//   matter only for timer events. Action code 3 is taken and ignored.
//   Output channel (out_valid/out_ready) carries period_ticks and
//   running_flag, one result per read request and nothing else.
//   cfg_we/cfg_wdata write timeout_ms; write only when idle.
// Timing
//   Events and ticks are absorbed in the accept cycle; in_ready stays high.
//   A read that finds pulses runs the restoring divider, one quotient bit
//   per cycle, then loads the output register once the receiver has room;
//   in_ready returns together with the result valid, so the next request
//   waits until the read is through.
//   A read without pulses skips the divider and goes straight to the
//   output load; its result and in_ready again return together.
// Reset and stall
//   rst_n clears all measurement state and sets timeout_ms to 500.
//   The output register holds a result until taken; a finished read
//   waits in the controller while the receiver stalls, and new requests
//   are held off only during a read.
module encoder_period_averager
    import epa_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    action,
    input  logic          overflow_flag,
    input  logic          capture_flag,
    input  logic [15:0]   capture_value,
    input  logic          direction,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [31:0]   period_ticks,
    output logic          running_flag,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata
);

    cmd_t    cmd;
    status_t status;

    // sequencing: accept, divider iterations, output hand-off
    epa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_action (action),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // measurement state, divider and output register
    epa_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .overflow_flag (overflow_flag),
        .capture_flag  (capture_flag),
        .capture_value (capture_value),
        .direction     (direction),
        .period_ticks  (period_ticks),
        .running_flag  (running_flag)
    );

endmodule

/* hw/rtl/epa_checker.sv */
// Port-level checker for encoder_period_averager, bound to the top level.
// Depends on epa_pkg.
module epa_checker
    import epa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  action,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] period_ticks,
    input logic        running_flag
);

    // a stalled result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(period_ticks))
        else $error("stalled result changed");

    // stopped measurement always reports a zero period
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !running_flag |-> period_ticks == 32'd0)
        else $error("nonzero period while stopped");

    // a read request blocks the input while it is computed
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action == ACT_READ |=> !in_ready)
        else $error("input open during read");

    // events, ticks and ignored codes never block the input
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action != ACT_READ |=> in_ready)
        else $error("input blocked after non-read request");

endmodule

bind encoder_period_averager epa_checker u_epa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .period_ticks (period_ticks),
    .running_flag (running_flag)
);

/* test/encoder_period_averager_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for encoder_period_averager: queued request driver,
// result monitor and an in-bench period predictor. Depends on epa_pkg and the RTL.
module encoder_period_averager_test;
    import epa_pkg::*;

    // One request on the input channel.
    typedef struct packed {
        action_t     act;
        logic        ovf;
        logic        cap;
        logic [15:0] val;
        logic        dir;
    } wheel_req_t;

    // One result on the output channel.
    typedef struct packed {
        logic [31:0] period;
        logic        running;
    } period_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  action = ACT_NONE;
    logic        overflow_flag = 1'b0;
    logic        capture_flag = 1'b0;
    logic [15:0] capture_value = '0;
    logic        direction = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] period_ticks;
    logic        running_flag;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;

    encoder_period_averager dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .overflow_flag (overflow_flag),
        .capture_flag  (capture_flag),
        .capture_value (capture_value),
        .direction     (direction),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .period_ticks  (period_ticks),
        .running_flag  (running_flag),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Run limit, several times the slowest legal run: about 800 requests
    // that could each be a full divide with worst-case idling on both
    // sides, plus the one long hold-off.
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor state: mirrors the block's measurement registers.
    // ------------------------------------------------------------------
    logic [15:0] timeout_cfg   = TimeoutReset;
    logic        meas_running  = 1'b0;
    logic        meas_last_dir = 1'b0;
    logic [31:0] ovf_extension = '0;
    logic [31:0] tick_sum      = '0;
    logic [31:0] pulse_total   = '0;
    logic [31:0] held_period   = '0;
    logic [15:0] ms_age        = '0;

    wheel_req_t     pending_reqs[$];    // requests not yet offered
    period_report_t period_expect_q[$]; // reads accepted, results not yet seen

    int unsigned fail_count = 0;
    logic        calm = 1'b0;            // no idling on either side
    logic        long_hold_armed = 1'b0; // ask the receiver for one long stall

    // Stop measurement: the overflow extension survives a stop.
    function automatic void halt_measurement();
        meas_running = 1'b0;
        tick_sum     = '0;
        pulse_total  = '0;
        held_period  = '0;
    endfunction

    // Apply one accepted request to the predictor; reads queue a result.
    function automatic void track_encoder(wheel_req_t r);
        period_report_t rep;
        case (r.act)
            ACT_EVENT:
            begin
                // direction change comes first, then overflow, then capture
                if (meas_last_dir != r.dir)
                begin
                    meas_last_dir = r.dir;
                    halt_measurement();
                end
                if (r.ovf)
                    ovf_extension = ovf_extension + OverflowStep;
                if (r.cap)
                begin
                    if (meas_running)
                    begin
                        tick_sum    = tick_sum + ovf_extension + {16'h0000, r.val};
                        pulse_total = pulse_total + 32'd1;
                    end
                    else
                    begin
                        // first capture after a stop only re-arms
                        meas_running = 1'b1;
                        tick_sum     = '0;
                        pulse_total  = '0;
                    end
                    ms_age        = '0;
                    ovf_extension = '0;
                end
            end
            ACT_TICK:
            begin
                if (ms_age != MsSaturate)
                    ms_age = ms_age + 16'd1;
            end
            ACT_READ:
            begin
                if (meas_running && ms_age > timeout_cfg)
                    halt_measurement();
                if (pulse_total != 0)
                begin
                    held_period = tick_sum / pulse_total;
                    tick_sum    = '0;
                    pulse_total = '0;
                end
                rep.period  = held_period;
                rep.running = meas_running;
                period_expect_q.push_back(rep);
            end
            default:
            begin
                // unused code: swallowed with no effect
            end
        endcase
    endfunction

    // Idle burst length for one side, 0 for none. Occasionally starts a
    // quiet stretch during which that side never idles.
    function automatic int unsigned idle_burst(inout int unsigned quiet);
        if (calm)
            return 0;
        if (quiet != 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if ($urandom_range(0, 5) == 0)
            return $urandom_range(1, 7);
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued requests, holds each until accepted, and
    // feeds accepted ones to the predictor.
    // ------------------------------------------------------------------
    wheel_req_t  shown_req;
    int unsigned send_gap = 0;
    int unsigned send_quiet = 0;

    always @(posedge clk)
    begin
        logic next_valid;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            next_valid = in_valid;
            if (in_valid && in_ready)
            begin
                track_encoder(shown_req);
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (send_gap != 0)
                    send_gap--;
                else if (pending_reqs.size() != 0)
                begin
                    shown_req = pending_reqs.pop_front();
                    action        <= shown_req.act;
                    overflow_flag <= shown_req.ovf;
                    capture_flag  <= shown_req.cap;
                    capture_value <= shown_req.val;
                    direction     <= shown_req.dir;
                    next_valid = 1'b1;
                    send_gap = idle_burst(send_quiet);
                end
            end
            in_valid <= next_valid;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks every taken result against the oldest expectation
    // and drives out_ready with random stalls plus one long hold-off.
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;
    int unsigned recv_quiet = 0;
    int unsigned hold_left = 0;
    logic        long_hold_done = 1'b0;

    always @(posedge clk)
    begin
        period_report_t want;
        logic next_ready;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (period_expect_q.size() == 0)
                begin
                    $error("unexpected result: period_ticks %0d running_flag %0d",
                           period_ticks, running_flag);
                    fail_count++;
                end
                else
                begin
                    want = period_expect_q.pop_front();
                    if (period_ticks !== want.period)
                    begin
                        $error("period_ticks expected %0d actual %0d",
                               want.period, period_ticks);
                        fail_count++;
                    end
                    if (running_flag !== want.running)
                    begin
                        $error("running_flag expected %0d actual %0d",
                               want.running, running_flag);
                        fail_count++;
                    end
                end
            end

            // long hold-off: the block fills and must push back on requests
            if (long_hold_armed && !long_hold_done)
            begin
                hold_left = 300;
                long_hold_done = 1'b1;
            end

            next_ready = 1'b1;
            if (hold_left != 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else
            begin
                if (stall_left == 0)
                    stall_left = idle_burst(recv_quiet);
                if (stall_left != 0)
                begin
                    stall_left--;
                    next_ready = 1'b0;
                end
            end
            out_ready <= next_ready;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_req(action_t a, logic o, logic c, logic [15:0] v, logic d);
        wheel_req_t r;
        r.act = a;
        r.ovf = o;
        r.cap = c;
        r.val = v;
        r.dir = d;
        pending_reqs.push_back(r);
    endtask

    // Block until everything offered is accepted and every read answered,
    // then let a full divide's worth of cycles pass.
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || in_valid || period_expect_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_timeout(logic [15:0] v);
        @(posedge clk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= v;
        timeout_cfg = v;
        @(posedge clk);
        cfg_we      <= 1'b0;
    endtask

    // Mostly well-formed rides (steady direction, captures with overflows,
    // tick runs, reads) with some direction flips, stray events and
    // unused-code noise mixed in. Noise is not counted.
    task automatic ride_mix(int unsigned count);
        int unsigned made;
        int unsigned pick;
        int unsigned n;
        logic [15:0] v;
        logic        ride_dir;
        made = 0;
        ride_dir = 1'($urandom_range(0, 1));
        while (made < count)
        begin
            if ($urandom_range(0, 29) == 0)
                ride_dir = ~ride_dir;
            case ($urandom_range(0, 9))
                0:       v = 16'h0000;
                1:       v = 16'hFFFF;
                default: v = 16'($urandom_range(0, 65535));
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                queue_req(ACT_EVENT, $urandom_range(0, 3) == 0,
                          $urandom_range(0, 9) < 6, v, ride_dir);
                made++;
            end
            else if (pick < 65)
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    queue_req(ACT_TICK, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)),
                              16'($urandom_range(0, 65535)),
                              1'($urandom_range(0, 1)));
                made += n;
            end
            else if (pick < 90)
            begin
                queue_req(ACT_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          v, 1'($urandom_range(0, 1)));
                made++;
            end
            else if (pick < 94)
            begin
                queue_req(ACT_EVENT, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          v, 1'($urandom_range(0, 1)));
                made++;
            end
            else
            begin
                queue_req(ACT_NONE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          v, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial
    begin
        logic [15:0] ride_timeouts[5];
        ride_timeouts[0] = 16'd7;
        ride_timeouts[1] = 16'd0;
        ride_timeouts[2] = 16'hFFFF;
        ride_timeouts[3] = 16'($urandom_range(1, 40));
        ride_timeouts[4] = 16'd2;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset timeout of 500.
        queue_req(ACT_READ,  1'b0, 1'b0, 16'h0000, 1'b0); // read straight from reset
        queue_req(ACT_NONE,  1'b1, 1'b1, 16'hFFFF, 1'b1); // unused code, all ones
        queue_req(ACT_EVENT, 1'b1, 1'b1, 16'hFFFF, 1'b1); // dir change + ovf + re-arm
        queue_req(ACT_EVENT, 1'b0, 1'b1, 16'h0000, 1'b1); // first pulse, zero value
        queue_req(ACT_EVENT, 1'b1, 1'b0, 16'h0000, 1'b1); // overflow alone
        queue_req(ACT_EVENT, 1'b1, 1'b1, 16'hFFFF, 1'b1); // overflow then capture
        queue_req(ACT_TICK,  1'b0, 1'b0, 16'h0000, 1'b1);
        queue_req(ACT_READ,  1'b0, 1'b0, 16'h0000, 1'b1); // divide by two pulses
        queue_req(ACT_READ,  1'b0, 1'b0, 16'h0000, 1'b1); // no pulses: held value
        queue_req(ACT_EVENT, 1'b0, 1'b0, 16'h0000, 1'b0); // direction change stops
        queue_req(ACT_READ,  1'b0, 1'b0, 16'h0000, 1'b0); // stopped reads zero
        queue_req(ACT_EVENT, 1'b0, 1'b1, 16'd123,  1'b0); // re-arm
        queue_req(ACT_EVENT, 1'b0, 1'b1, 16'h8000, 1'b0);
        queue_req(ACT_EVENT, 1'b0, 1'b0, 16'h5A5A, 1'b0); // value without capture
        queue_req(ACT_NONE,  1'b0, 1'b0, 16'h0000, 1'b0); // unused code, all zeros
        queue_req(ACT_TICK,  1'b0, 1'b0, 16'h0000, 1'b0);
        queue_req(ACT_READ,  1'b0, 1'b0, 16'h0000, 1'b0);
        wait_idle();

        // Directed, zero timeout: a single tick past a capture stops a read.
        set_timeout(16'd0);
        queue_req(ACT_EVENT, 1'b0, 1'b1, 16'd10, 1'b0);
        queue_req(ACT_READ,  1'b0, 1'b0, 16'd0,  1'b0); // age 0, not past timeout
        queue_req(ACT_TICK,  1'b0, 1'b0, 16'd0,  1'b0);
        queue_req(ACT_READ,  1'b0, 1'b0, 16'd0,  1'b0); // timed out
        queue_req(ACT_EVENT, 1'b0, 1'b1, 16'd7,  1'b0); // re-arm
        queue_req(ACT_TICK,  1'b0, 1'b0, 16'd0,  1'b0);
        queue_req(ACT_EVENT, 1'b0, 1'b1, 16'd7,  1'b0); // capture clears the age
        queue_req(ACT_READ,  1'b0, 1'b0, 16'd0,  1'b0);
        wait_idle();

        // Random rides over a spread of timeouts; the last one runs with
        // no idling on either side.
        for (int i = 0; i < 5; i++)
        begin
            set_timeout(ride_timeouts[i]);
            if (i == 1)
                long_hold_armed <= 1'b1;
            if (i == 4)
                calm <= 1'b1;
            ride_mix(135);
            wait_idle();
        end

        // Closing run, still no idling. With the largest timeout a tick
        // run never stops measurement.
        set_timeout(16'hFFFF);
        queue_req(ACT_READ,  1'b0, 1'b0, 16'h0000, 1'b0); // flush pending pulses
        queue_req(ACT_EVENT, 1'b0, 1'b1, 16'h0005, 1'b0);
        queue_req(ACT_EVENT, 1'b1, 1'b1, 16'hFFFF, 1'b0); // overflow then capture
        queue_req(ACT_EVENT, 1'b0, 1'b1, 16'h0100, 1'b0);
        repeat (20)
            queue_req(ACT_TICK, 1'b0, 1'b0, 16'h0000, 1'b0);
        queue_req(ACT_READ,  1'b0, 1'b0, 16'h0000, 1'b0); // largest timeout never fires
        wait_idle();

        // Counter sits at 20, one above this timeout.
        set_timeout(16'd19);
        queue_req(ACT_READ, 1'b0, 1'b0, 16'h0000, 1'b0);
        wait_idle();

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
